>>> design/tcmc_pkg.sv
// shared types, widths and constants of the timed cover motor controller
package tcmc_pkg;

  localparam int unsigned POS_W    = 17;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CUR_W    = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned TRAVEL_W = 24;
  localparam int unsigned SHORT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned STEP_W    = 18;
  localparam int unsigned NUM_W     = TIME_W + 17;
  localparam int unsigned DIV_STEPS = STEP_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [POS_W-1:0]  Q_ONE         = 17'd65536;
  localparam logic [POS_W-1:0]  ALMOST_OPEN   = 17'd64881;
  localparam logic [POS_W-1:0]  ALMOST_CLOSED = 17'd655;
  localparam logic [POS_W-1:0]  POS_RESET     = 17'd32768;
  localparam logic [STEP_W-1:0] STEP_MAX      = 18'd131072;
  localparam logic signed [DUTY_W-1:0] FULL_DUTY = 8'sd127;

  localparam logic [TRAVEL_W-1:0] OPEN_TIME_RESET   = 24'd10000;
  localparam logic [TRAVEL_W-1:0] CLOSE_TIME_RESET  = 24'd10000;
  localparam logic [SHORT_W-1:0]  SPINUP_RESET      = 16'd0;
  localparam logic [SHORT_W-1:0]  MOVING_CUR_RESET  = 16'd100;
  localparam logic [SHORT_W-1:0]  REPORT_INT_RESET  = 16'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_STOP = 2'd1,
    MODE_MOVE = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_OPENING = 2'd1,
    OP_CLOSING = 2'd2
  } op_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_TIME  = 3'd0,
    CFG_CLOSE_TIME = 3'd1,
    CFG_SPINUP     = 3'd2,
    CFG_MOVING_CUR = 3'd3,
    CFG_REPORT_INT = 3'd4,
    CFG_POS_OPENS  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic prep_a;
    logic prep_b;
    logic num;
    logic div_step;
    logic apply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic do_div;
  } status_t;

endpackage

>>> design/tcmc_in_if.sv
// input item channel
interface tcmc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcmc_pkg::MODE_W-1:0]    mode;
  logic [tcmc_pkg::POS_W-1:0]     goal_position;
  logic [tcmc_pkg::TIME_W-1:0]    time_ms;
  logic [tcmc_pkg::CUR_W-1:0]     motor_current_ma;

  modport source (output valid, mode, goal_position, time_ms, motor_current_ma,
                  input ready);
  modport sink (input valid, mode, goal_position, time_ms, motor_current_ma,
                output ready);
endinterface

>>> design/tcmc_out_if.sv
// result item channel
interface tcmc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcmc_pkg::DUTY_W-1:0]  motor_duty;
  logic [tcmc_pkg::POS_W-1:0]          cover_position;
  logic [1:0]                          cover_state;
  logic                                report_now;
  logic                                motor_moving;

  modport source (output valid, motor_duty, cover_position, cover_state, report_now,
                  motor_moving, input ready);
  modport sink (input valid, motor_duty, cover_position, cover_state, report_now,
                motor_moving, output ready);
endinterface

>>> design/tcmc_ctrl.sv
// sequencing state machine: accept, prepare, divide, update, deliver
module tcmc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tcmc_pkg::status_t  status_i,
  output tcmc_pkg::cmd_t     cmd_o
);
  import tcmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP_A,
    S_PREP_B,
    S_NUM,
    S_DIV,
    S_APPLY,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             fin_fire;

  assign fin_fire    = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep_a   = (state_q == S_PREP_A);
    cmd_o.prep_b   = (state_q == S_PREP_B);
    cmd_o.num      = (state_q == S_NUM);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.apply    = (state_q == S_APPLY);
    cmd_o.finish   = fin_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP_A;
          end
        end
        S_PREP_A: state_q <= S_PREP_B;
        S_PREP_B: state_q <= S_NUM;
        S_NUM: begin
          if (status_i.do_div) begin
            cnt_q   <= CNT_W'(DIV_STEPS - 1);
            state_q <= S_DIV;
          end else begin
            state_q <= S_APPLY;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_APPLY;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_APPLY: state_q <= S_FINISH;
        S_FINISH: begin
          if (fin_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/tcmc_dp.sv
// datapath: registers, position tracking, restoring divider and result register
module tcmc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tcmc_pkg::cmd_t                       cmd_i,
  output tcmc_pkg::status_t                    status_o,
  input  logic [tcmc_pkg::MODE_W-1:0]          mode_i,
  input  logic [tcmc_pkg::POS_W-1:0]           goal_i,
  input  logic [tcmc_pkg::TIME_W-1:0]          time_i,
  input  logic [tcmc_pkg::CUR_W-1:0]           cur_i,
  input  logic                                 cfg_we_i,
  input  logic [tcmc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tcmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic signed [tcmc_pkg::DUTY_W-1:0]   duty_o,
  output logic [tcmc_pkg::POS_W-1:0]           pos_o,
  output logic [1:0]                           state_o,
  output logic                                 report_o,
  output logic                                 moving_o
);
  import tcmc_pkg::*;

  // configuration
  logic [TRAVEL_W-1:0] open_time_q, close_time_q;
  logic [SHORT_W-1:0]  spinup_q, moving_cur_q, report_int_q;
  logic                pos_opens_q;

  // tracker state
  logic [POS_W-1:0]  pos_q, goal_q;
  op_state_e         op_q;
  logic [TIME_W-1:0] start_q, last_upd_q, last_rep_q;
  logic              moving_q;

  // current transaction
  mode_e             mode_q;
  logic [POS_W-1:0]  igoal_q;
  logic [TIME_W-1:0] now_q;
  logic [CUR_W-1:0]  cur_q;

  // work registers
  logic [TIME_W-1:0]   t0_q, elapsed_q;
  logic [TRAVEL_W-1:0] span_q, rem_q;
  logic                wait_ge_q, count_q, sat_q;
  logic [STEP_W-1:0]   nlow_q, quo_q;

  // result register
  logic signed [DUTY_W-1:0] duty_q;
  logic [POS_W-1:0]         opos_q;
  logic [1:0]               ostate_q;
  logic                     orep_q, omov_q;

  logic                active, opening;
  logic [TRAVEL_W-1:0] dur;
  logic [TIME_W-1:0]   from_t;
  logic [NUM_W-1:0]    num_w;
  logic                num_sat;
  logic [TRAVEL_W:0]   trial, diff;
  logic                trial_ge;
  logic [STEP_W-1:0]   d;
  logic [POS_W-1:0]    lo, hi;
  logic [STEP_W-1:0]   praw, pclamp;

  logic                reached;
  logic [POS_W-1:0]    pos_n, goal_n;
  op_state_e           op_n;
  logic [TIME_W-1:0]   start_n, last_rep_n;
  logic                rep_n;
  logic signed [DUTY_W-1:0] duty_n;

  assign active  = (mode_q == MODE_TICK) && (op_q != OP_IDLE);
  assign opening = (op_q == OP_OPENING);
  assign dur     = opening ? open_time_q : close_time_q;
  assign from_t  = (t0_q > last_upd_q) ? t0_q : last_upd_q;

  // rounded numerator: elapsed * 65536 + span / 2, with its carry
  assign num_w   = {1'b0, elapsed_q, 16'd0} + NUM_W'(span_q[TRAVEL_W-1:1]);
  assign num_sat = num_w[NUM_W-1:STEP_W] >= (NUM_W - STEP_W)'(span_q);
  assign status_o.do_div = active && count_q && !wait_ge_q && !num_sat;

  assign trial    = {rem_q, nlow_q[STEP_W-1]};
  assign trial_ge = trial >= {1'b0, span_q};
  assign diff     = trial - {1'b0, span_q};

  always_comb begin
    if (sat_q || quo_q > STEP_MAX) begin
      d = STEP_MAX;
    end else begin
      d = quo_q;
    end
    if (opening) begin
      lo = '0;
      hi = (pos_q < Q_ONE) ? ALMOST_OPEN : Q_ONE;
    end else begin
      lo = (pos_q > '0) ? ALMOST_CLOSED : '0;
      hi = Q_ONE;
    end
    if (wait_ge_q) begin
      praw = opening ? STEP_W'(hi) : STEP_W'(lo);
    end else if (opening) begin
      praw = STEP_W'(pos_q) + d;
    end else begin
      praw = (STEP_W'(pos_q) > d) ? STEP_W'(pos_q) - d : '0;
    end
    priority if (praw < STEP_W'(lo)) begin
      pclamp = STEP_W'(lo);
    end else if (praw > STEP_W'(hi)) begin
      pclamp = STEP_W'(hi);
    end else begin
      pclamp = praw;
    end
  end

  always_comb begin
    unique case (op_q)
      OP_OPENING: reached = (goal_q == Q_ONE) ? (pos_q >= ALMOST_OPEN && !moving_q)
                                              : (pos_q >= goal_q);
      OP_CLOSING: reached = (goal_q == '0) ? (pos_q <= ALMOST_CLOSED && !moving_q)
                                           : (pos_q <= goal_q);
      default:    reached = 1'b1;
    endcase
    pos_n      = pos_q;
    goal_n     = goal_q;
    op_n       = op_q;
    start_n    = start_q;
    last_rep_n = last_rep_q;
    rep_n      = 1'b0;
    unique case (mode_q)
      MODE_TICK: begin
        if (active) begin
          if (reached) begin
            pos_n   = goal_q;
            op_n    = OP_IDLE;
            start_n = now_q;
            rep_n   = 1'b1;
          end else if ((now_q - last_rep_q) > TIME_W'(report_int_q)) begin
            rep_n      = 1'b1;
            last_rep_n = now_q;
          end
        end
      end
      MODE_STOP: begin
        op_n    = OP_IDLE;
        start_n = now_q;
        rep_n   = 1'b1;
      end
      MODE_MOVE: begin
        if (igoal_q != pos_q) begin
          goal_n  = igoal_q;
          op_n    = (igoal_q < pos_q) ? OP_CLOSING : OP_OPENING;
          start_n = now_q;
          rep_n   = 1'b1;
        end
      end
      default: ;
    endcase
    unique case (op_n)
      OP_OPENING: duty_n = pos_opens_q ? FULL_DUTY : -FULL_DUTY;
      OP_CLOSING: duty_n = pos_opens_q ? -FULL_DUTY : FULL_DUTY;
      default:    duty_n = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_time_q  <= OPEN_TIME_RESET;
      close_time_q <= CLOSE_TIME_RESET;
      spinup_q     <= SPINUP_RESET;
      moving_cur_q <= MOVING_CUR_RESET;
      report_int_q <= REPORT_INT_RESET;
      pos_opens_q  <= 1'b1;
      pos_q        <= POS_RESET;
      goal_q       <= '0;
      op_q         <= OP_IDLE;
      start_q      <= '0;
      last_upd_q   <= '0;
      last_rep_q   <= '0;
      moving_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OPEN_TIME:  open_time_q  <= cfg_data_i;
          CFG_CLOSE_TIME: close_time_q <= cfg_data_i;
          CFG_SPINUP:     spinup_q     <= cfg_data_i[SHORT_W-1:0];
          CFG_MOVING_CUR: moving_cur_q <= cfg_data_i[SHORT_W-1:0];
          CFG_REPORT_INT: report_int_q <= cfg_data_i[SHORT_W-1:0];
          CFG_POS_OPENS:  pos_opens_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.apply && active) begin
        if (count_q) begin
          pos_q <= pclamp[POS_W-1:0];
        end
        last_upd_q <= now_q;
        moving_q   <= cur_q >= moving_cur_q;
      end
      if (cmd_i.finish) begin
        pos_q      <= pos_n;
        goal_q     <= goal_n;
        op_q       <= op_n;
        start_q    <= start_n;
        last_rep_q <= last_rep_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      igoal_q <= (goal_i > Q_ONE) ? Q_ONE : goal_i;
      now_q   <= time_i;
      cur_q   <= cur_i;
    end
    if (cmd_i.prep_a) begin
      t0_q      <= start_q + TIME_W'(spinup_q);
      span_q    <= dur - TRAVEL_W'(spinup_q);
      wait_ge_q <= dur <= TRAVEL_W'(spinup_q);
    end
    if (cmd_i.prep_b) begin
      count_q   <= now_q > t0_q;
      elapsed_q <= now_q - from_t;
    end
    if (cmd_i.num) begin
      sat_q  <= num_sat;
      rem_q  <= num_w[STEP_W +: TRAVEL_W];
      nlow_q <= num_w[STEP_W-1:0];
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? diff[TRAVEL_W-1:0] : trial[TRAVEL_W-1:0];
      nlow_q <= {nlow_q[STEP_W-2:0], 1'b0};
      quo_q  <= {quo_q[STEP_W-2:0], trial_ge};
    end
    if (cmd_i.finish) begin
      duty_q   <= duty_n;
      opos_q   <= pos_n;
      ostate_q <= op_n;
      orep_q   <= rep_n;
      omov_q   <= moving_q;
    end
  end

  assign duty_o   = duty_q;
  assign pos_o    = opos_q;
  assign state_o  = ostate_q;
  assign report_o = orep_q;
  assign moving_o = omov_q;

endmodule

>>> design/timed_cover_motor_controller.sv
// Time-based cover position tracker with motor duty control. One transaction is
// taken at a time: a tick that needs a division runs the 18-step restoring
// divider, which computes (elapsed * 65536 + span / 2) / travel span; stop,
// move and all other ticks skip the divider. The next transaction can be
// accepted in the same cycle in which the result becomes ready. The result
// sits in an output register, so the next transaction is accepted while the
// previous result waits to be taken. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module timed_cover_motor_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tcmc_in_if.sink                         item_i,
  tcmc_out_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [tcmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tcmc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcmc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .mode_i     (item_i.mode),
    .goal_i     (item_i.goal_position),
    .time_i     (item_i.time_ms),
    .cur_i      (item_i.motor_current_ma),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .duty_o     (res_o.motor_duty),
    .pos_o      (res_o.cover_position),
    .state_o    (res_o.cover_state),
    .report_o   (res_o.report_now),
    .moving_o   (res_o.motor_moving)
  );

endmodule
